// ----- src/lhxbp_pkg.sv -----
// shared types, constants and counter update function for the local history predictor
package lhxbp_pkg;

    // item codes carried on the slave tuser bit
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // stream layout
    localparam int PC_W       = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int TAKEN_BIT  = 32;

    // 2-bit saturating direction counter
    localparam int         CTR_W     = 2;
    localparam logic [1:0] CTR_MAX   = 2'd3;
    localparam logic [1:0] CTR_MIN   = 2'd0;
    localparam logic [1:0] CTR_RESET = 2'd2;

    typedef logic [CTR_W-1:0] ctr_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_CTR
    } lhxbp_state_t;

    // one saturating step toward the resolved direction
    function automatic ctr_t ctr_step(input ctr_t ctr, input logic dir);
        ctr_t res;
        res = ctr;
        if (dir)
        begin
            if (ctr != CTR_MAX)
                res = ctr + 2'd1;
        end
        else
        begin
            if (ctr != CTR_MIN)
                res = ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

// ----- src/local_history_xor_branch_predictor.sv -----
// top level of the two-level local history branch predictor with xor counter index
// Two-level local-history branch predictor. Each slave transaction is a predict
// (tuser = 0) or an update (tuser = 1) for one branch address, and every transaction
// yields exactly one master transaction carrying the prediction made from the state
// before that item. The low HIST_BITS address bits pick a per-branch history; the
// history xored with the address picks a 2-bit saturating counter whose upper bit is
// the prediction. An update steps the counter toward the resolved direction and
// shifts the direction into that branch's history. Both tables live in synchronous
// ram with a registered read port. After reset the block sweeps all 2**HIST_BITS
// entries of both rams (16384 at the default), one entry per cycle, with s_tready
// low. Afterwards a transaction makes the history read, then the dependent counter
// read; the result is registered as the item retires from the counter stage, and
// the next transaction is accepted in that same cycle, so a new item can enter as
// the last one retires while the master side keeps up. A history write that meets
// a read of the same entry in the same cycle is forwarded.
module local_history_xor_branch_predictor #(
    parameter int HIST_BITS = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lhxbp_pkg::S_TDATA_W-1:0] s_tdata,  // branch_pc[31:0], taken[32], zeros
    input  logic                            s_tuser,  // opcode
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lhxbp_pkg::M_TDATA_W-1:0] m_tdata   // predict_taken[0], zeros
);

    localparam logic [HIST_BITS-1:0] IDX_LAST = '1;

    lhxbp_pkg::lhxbp_state_t state_reg, state_next;

    // clearing sweep
    logic [HIST_BITS-1:0] clr_idx_reg, clr_idx_next;

    // item being worked on
    logic                 op_reg;
    logic                 taken_reg;
    logic [HIST_BITS-1:0] hslot_reg;
    logic [HIST_BITS-1:0] hist_reg;
    logic [HIST_BITS-1:0] cslot_reg;

    // history forwarding for a read that meets the write of the same entry
    logic                 fwd_hit_reg, fwd_hit_next;
    logic [HIST_BITS-1:0] fwd_data_reg;

    // output register
    logic out_valid_reg, out_valid_next;
    logic out_taken_reg;

    // handshake and control
    logic accept;
    logic slot_free;
    logic finish;
    logic do_update;

    // history ram
    logic                 hist_we;
    logic [HIST_BITS-1:0] hist_waddr;
    logic [HIST_BITS-1:0] hist_wdata;
    logic [HIST_BITS-1:0] hist_rdata;
    logic [HIST_BITS-1:0] hist_new;
    logic [HIST_BITS-1:0] hist_cur;
    logic [HIST_BITS-1:0] in_hslot;

    // counter ram
    logic                 ctr_we;
    logic [HIST_BITS-1:0] ctr_waddr;
    lhxbp_pkg::ctr_t      ctr_wdata;
    logic                 ctr_re;
    logic [HIST_BITS-1:0] ctr_raddr;
    lhxbp_pkg::ctr_t      ctr_rdata;

    assign in_hslot  = s_tdata[HIST_BITS-1:0];
    assign slot_free = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign hist_new  = {hist_reg[HIST_BITS-2:0], taken_reg};
    assign hist_cur  = fwd_hit_reg ? fwd_data_reg : hist_rdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lhxbp_pkg::ST_CLEAR:
            begin
                if (clr_idx_reg == IDX_LAST)
                    state_next = lhxbp_pkg::ST_IDLE;
            end
            lhxbp_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = lhxbp_pkg::ST_HIST;
            end
            lhxbp_pkg::ST_HIST:
            begin
                state_next = lhxbp_pkg::ST_CTR;
            end
            lhxbp_pkg::ST_CTR:
            begin
                if (slot_free)
                    state_next = s_tvalid ? lhxbp_pkg::ST_HIST : lhxbp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lhxbp_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_tready = 1'b0;
        finish   = 1'b0;
        ctr_re   = 1'b0;
        case (state_reg)
            lhxbp_pkg::ST_CLEAR:
            begin
                s_tready = 1'b0;
            end
            lhxbp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            lhxbp_pkg::ST_HIST:
            begin
                ctr_re = 1'b1;
            end
            lhxbp_pkg::ST_CTR:
            begin
                // result retires and the next item can enter in the same cycle
                s_tready = slot_free;
                finish   = slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign do_update = finish && (op_reg == lhxbp_pkg::OP_UPDATE);

    // ram write and read controls; the sweep writes both tables at one address
    always_comb
    begin
        if (state_reg == lhxbp_pkg::ST_CLEAR)
        begin
            hist_we    = 1'b1;
            hist_waddr = clr_idx_reg;
            hist_wdata = '0;
            ctr_we     = 1'b1;
            ctr_waddr  = clr_idx_reg;
            ctr_wdata  = lhxbp_pkg::CTR_RESET;
        end
        else
        begin
            hist_we    = do_update;
            hist_waddr = hslot_reg;
            hist_wdata = hist_new;
            ctr_we     = do_update;
            ctr_waddr  = cslot_reg;
            ctr_wdata  = lhxbp_pkg::ctr_step(ctr_rdata, taken_reg);
        end
    end

    assign ctr_raddr = hslot_reg ^ hist_cur;

    assign clr_idx_next = (state_reg == lhxbp_pkg::ST_CLEAR) ? clr_idx_reg + 1'b1 : clr_idx_reg;
    assign fwd_hit_next = accept && do_update && (in_hslot == hslot_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lhxbp_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_tuser;
            taken_reg <= s_tdata[lhxbp_pkg::TAKEN_BIT];
            hslot_reg <= in_hslot;
        end
        if (state_reg == lhxbp_pkg::ST_HIST)
        begin
            hist_reg  <= hist_cur;
            cslot_reg <= ctr_raddr;
        end
        if (do_update)
            fwd_data_reg <= hist_new;
        if (finish)
            out_taken_reg <= ctr_rdata[lhxbp_pkg::CTR_W-1];
    end

    // per-branch history table
    lhxbp_ram #(
        .DATA_W(HIST_BITS),
        .ADDR_W(HIST_BITS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (accept),
        .raddr (in_hslot),
        .rdata (hist_rdata)
    );

    // direction counter table
    lhxbp_ram #(
        .DATA_W(lhxbp_pkg::CTR_W),
        .ADDR_W(HIST_BITS)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (ctr_waddr),
        .wdata (ctr_wdata),
        .re    (ctr_re),
        .raddr (ctr_raddr),
        .rdata (ctr_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lhxbp_pkg::M_TDATA_W-1){1'b0}}, out_taken_reg};

    // an accepted transaction always goes on to its history lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == lhxbp_pkg::ST_HIST)
        else $error("accepted transaction did not start history lookup");

    // a result only appears when an item retires from the counter stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == lhxbp_pkg::ST_CTR)
        else $error("result appeared outside counter stage");

    // forwarded history is only consumed in the history stage
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> state_reg == lhxbp_pkg::ST_HIST)
        else $error("history forward outside history stage");

    // table writes outside the sweep come only from update items
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctr_we && state_reg != lhxbp_pkg::ST_CLEAR) |-> op_reg == lhxbp_pkg::OP_UPDATE)
        else $error("counter written by a predict item");

    // no transaction is taken while the tables are being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lhxbp_pkg::ST_CLEAR |-> !accept && !out_valid_reg)
        else $error("traffic during clearing sweep");

endmodule

// ----- src/lhxbp_ram.sv -----
// simple dual-port synchronous ram, one write port and one registered read port
module lhxbp_ram #(
    parameter int DATA_W = 2,
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
